[rtl/bis_pkg.sv]
`default_nettype none
package bis_pkg;

    // Fixed field widths
    localparam int PW   = 10;           // position field
    localparam int CW   = 11;           // size register
    localparam int CCW  = 3;            // channel count register
    localparam int CHN  = 4;            // channels per pixel
    localparam int PIXW = 16;           // channel field

    // Axis mapping arithmetic
    localparam int NW    = 2 * CW + 1;  // signed numerator (2p+1)*src - dst
    localparam int REMW  = NW - 1;      // divider remainder
    localparam int DW    = CW + 1;      // denominator 2*dst
    localparam int QW    = CW;          // floor index
    localparam int DSW   = DW + QW - 1; // shifted denominator
    localparam int AXW   = DW + 2;      // signed axis weight
    localparam int WPW   = 2 * AXW;     // product of two axis weights
    localparam int PRODW = 2 * DW;      // product of two denominators
    localparam int ACCW  = PIXW + 1 + WPW + 2;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_SRC_W  = 3'd0,
        REG_SRC_H  = 3'd1,
        REG_DST_W  = 3'd2,
        REG_DST_H  = 3'd3,
        REG_SRC_CH = 3'd4,
        REG_DST_CH = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic       capture;
        logic       wr_en;
        logic       ax_step;
        logic       wprod;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       q_init;
        logic       q_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic load_ok;
        logic sample_ok;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

[rtl/bis_ram.sv]
`default_nettype none
module bis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

[rtl/bis_ctrl.sv]
`default_nettype none
module bis_ctrl
    import bis_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  operation,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam int QB    = SAMPLE_BITS + 2;
    localparam int STEPS = (QB > QW) ? QB : QW;
    localparam int CNTW  = $clog2(STEPS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_WPROD = 7'b0000100,
        S_READ  = 7'b0001000,
        S_QINIT = 7'b0010000,
        S_QDIV  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequence one transaction through the datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.wr_en = stat.load_ok;
                    end
                    else if (stat.sample_ok)
                    begin
                        cmd.capture = 1'b1;
                        cnt_next    = '0;
                        state_next  = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.ax_step = 1'b1;
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_WPROD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WPROD:
            begin
                cmd.wprod  = 1'b1;
                cnt_next   = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = (cnt_reg < CNTW'(CHN));
                cmd.rd_sel = cnt_reg[1:0];
                if (cnt_reg == CNTW'(CHN))
                begin
                    cnt_next   = '0;
                    state_next = S_QINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_QINIT:
            begin
                cmd.q_init = 1'b1;
                cnt_next   = '0;
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                cmd.q_step = 1'b1;
                if (cnt_reg == CNTW'(QB - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // An accepted valid sample starts the coordinate division
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == OP_SAMPLE && stat.sample_ok)
        |=> (state_reg == S_DIV))
        else $error("sample transaction did not start division");

    // Frame writes happen only between samples
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg == S_IDLE && in_valid))
        else $error("frame write outside idle");

    // A result is preceded by the full blend division
    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && $past(state_reg) != S_OUT) |-> $past(cmd.q_step))
        else $error("result without finished division");

endmodule
`default_nettype wire

[rtl/bis_datapath.sv]
`default_nettype none
module bis_datapath
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CW-1:0]    source_width,
    input  wire logic [CW-1:0]    source_height,
    input  wire logic [CW-1:0]    target_width,
    input  wire logic [CW-1:0]    target_height,
    input  wire logic [CCW-1:0]   source_channel_count,
    input  wire logic [CCW-1:0]   target_channel_count,
    input  wire logic [PW-1:0]    pos_x,
    input  wire logic [PW-1:0]    pos_y,
    input  wire logic [PIXW-1:0]  in_chan_0,
    input  wire logic [PIXW-1:0]  in_chan_1,
    input  wire logic [PIXW-1:0]  in_chan_2,
    input  wire logic [PIXW-1:0]  in_chan_3,
    input  wire cmd_t             cmd,
    output stat_t                 stat,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [PW-1:0]         out_x,
    output logic [PW-1:0]         out_y,
    output logic [PIXW-1:0]       out_chan_0,
    output logic [PIXW-1:0]       out_chan_1,
    output logic [PIXW-1:0]       out_chan_2,
    output logic [PIXW-1:0]       out_chan_3
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int QB     = SAMPLE_BITS + 2;
    localparam int QDW    = PRODW + QB - 1;
    localparam int NUMW   = ACCW - 1;
    localparam int MULW   = PIXW + 1 + WPW;
    localparam logic [PIXW-1:0] FULL = PIXW'((1 << SAMPLE_BITS) - 1);

    // Clamp channel counts and check the item against the configuration
    logic [CCW-1:0] sc, tc, common;
    logic           size_ok;

    always_comb
    begin
        sc      = (source_channel_count > CCW'(CHN)) ? CCW'(CHN) : source_channel_count;
        tc      = (target_channel_count > CCW'(CHN)) ? CCW'(CHN) : target_channel_count;
        common  = (sc < tc) ? sc : tc;
        size_ok = (source_width != '0) && (source_height != '0) &&
                  (target_width != '0) && (target_height != '0) &&
                  (32'(source_width) <= MAX_WIDTH) && (32'(target_width) <= MAX_WIDTH) &&
                  (32'(source_height) <= MAX_HEIGHT) && (32'(target_height) <= MAX_HEIGHT);
        stat.sample_ok = size_ok && (CW'(pos_x) < target_width) &&
                         (CW'(pos_y) < target_height) && (common != '0);
        stat.load_ok   = (32'(source_width) <= MAX_WIDTH) &&
                         (32'(source_height) <= MAX_HEIGHT) &&
                         (CW'(pos_x) < source_width) && (CW'(pos_y) < source_height);
        stat.out_busy  = out_valid && !out_ready;
    end

    // Axis numerators at capture
    logic [2*CW-1:0]     mx, my;
    logic signed [NW-1:0] numx, numy;

    always_comb
    begin
        mx   = (2*CW)'({pos_x, 1'b1}) * (2*CW)'(source_width);
        my   = (2*CW)'({pos_y, 1'b1}) * (2*CW)'(source_height);
        numx = $signed({1'b0, mx}) - $signed(NW'(target_width));
        numy = $signed({1'b0, my}) - $signed(NW'(target_height));
    end

    // Two restoring dividers, one per axis (index 0 is x, 1 is y)
    logic [PW-1:0]   px_reg, py_reg;
    logic            neg_reg [2];
    logic [REMW-1:0] rem_reg [2];
    logic [DSW-1:0]  dsh_reg [2];
    logic [QW-1:0]   quo_reg [2];
    logic [DW-1:0]   d_reg   [2];
    logic [CW-1:0]   src_reg [2];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            neg_reg[0] <= numx[NW-1];
            neg_reg[1] <= numy[NW-1];
            rem_reg[0] <= numx[REMW-1:0];
            rem_reg[1] <= numy[REMW-1:0];
            d_reg[0]   <= {target_width, 1'b0};
            d_reg[1]   <= {target_height, 1'b0};
            dsh_reg[0] <= DSW'({target_width, 1'b0}) << (QW - 1);
            dsh_reg[1] <= DSW'({target_height, 1'b0}) << (QW - 1);
            quo_reg[0] <= '0;
            quo_reg[1] <= '0;
            src_reg[0] <= source_width;
            src_reg[1] <= source_height;
        end
        else if (cmd.ax_step)
        begin
            for (int a = 0; a < 2; a++)
            begin
                if (!neg_reg[a])
                begin
                    if (rem_reg[a] >= REMW'(dsh_reg[a]))
                    begin
                        rem_reg[a] <= rem_reg[a] - REMW'(dsh_reg[a]);
                        quo_reg[a] <= {quo_reg[a][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_reg[a] <= {quo_reg[a][QW-2:0], 1'b0};
                    end
                end
                dsh_reg[a] <= dsh_reg[a] >> 1;
            end
        end
    end

    // Neighbor indices and weights from the finished division
    logic [CW-1:0]         lo [2];
    logic [CW-1:0]         hi [2];
    logic signed [AXW-1:0] a0 [2];
    logic signed [AXW-1:0] a1 [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            lo[a] = quo_reg[a];
            hi[a] = (quo_reg[a] == src_reg[a] - 1'b1) ? quo_reg[a] : quo_reg[a] + 1'b1;
            a1[a] = $signed(rem_reg[a][AXW-1:0]);
            a0[a] = $signed({2'b00, d_reg[a]}) - a1[a];
        end
    end

    // Weight products and common denominator
    logic signed [WPW-1:0] wp_reg [CHN];
    logic [PRODW-1:0]      prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wprod)
        begin
            wp_reg[0] <= a0[0] * a0[1];
            wp_reg[1] <= a1[0] * a0[1];
            wp_reg[2] <= a0[0] * a1[1];
            wp_reg[3] <= a1[0] * a1[1];
            prod_reg  <= d_reg[0] * d_reg[1];
        end
    end

    // Frame memory port: write on load, otherwise neighbor read
    logic [CW-1:0]             rx, ry;
    logic [ADDR_W-1:0]         waddr, raddr;
    logic [CHN*PIXW-1:0]       wdata, rdata;

    always_comb
    begin
        rx    = cmd.rd_sel[0] ? hi[0] : lo[0];
        ry    = cmd.rd_sel[1] ? hi[1] : lo[1];
        raddr = ADDR_W'(ry) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx);
        waddr = ADDR_W'(pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pos_x);
        wdata = {in_chan_3 & FULL, in_chan_2 & FULL, in_chan_1 & FULL, in_chan_0 & FULL};
    end

    bis_ram #(
        .WIDTH (CHN * PIXW),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (cmd.wr_en),
        .addr  (cmd.wr_en ? waddr : raddr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // Accumulate each neighbor in the cycle after its read, when its registered read data arrives
    logic                   acc_pend_reg;
    logic [1:0]             acc_sel_reg;
    logic signed [ACCW-1:0] acc_reg [CHN];
    logic signed [MULW-1:0] mul [CHN];

    always_comb
    begin
        for (int c = 0; c < CHN; c++)
        begin
            mul[c] = $signed({1'b0, rdata[c*PIXW +: PIXW]}) * wp_reg[acc_sel_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_pend_reg <= 1'b0;
        end
        else
        begin
            acc_pend_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_sel_reg <= cmd.rd_sel;
        if (cmd.wprod)
        begin
            for (int c = 0; c < CHN; c++)
            begin
                acc_reg[c] <= '0;
            end
        end
        else if (acc_pend_reg)
        begin
            for (int c = 0; c < CHN; c++)
            begin
                acc_reg[c] <= acc_reg[c] + ACCW'(mul[c]);
            end
        end
    end

    // Rounded division of each sum by the denominator, one bit per cycle
    logic              qneg_reg [CHN];
    logic [NUMW-1:0]   qrem_reg [CHN];
    logic [QB-1:0]     qquo_reg [CHN];
    logic [QDW-1:0]    qdsh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.q_init)
        begin
            qdsh_reg <= QDW'(prod_reg) << (QB - 1);
            for (int c = 0; c < CHN; c++)
            begin
                qneg_reg[c] <= (acc_reg[c] <= 0);
                qrem_reg[c] <= acc_reg[c][NUMW-1:0] + NUMW'(prod_reg >> 1);
                qquo_reg[c] <= '0;
            end
        end
        else if (cmd.q_step)
        begin
            qdsh_reg <= qdsh_reg >> 1;
            for (int c = 0; c < CHN; c++)
            begin
                if (qrem_reg[c] >= NUMW'(qdsh_reg))
                begin
                    qrem_reg[c] <= qrem_reg[c] - NUMW'(qdsh_reg);
                    qquo_reg[c] <= {qquo_reg[c][QB-2:0], 1'b1};
                end
                else
                begin
                    qquo_reg[c] <= {qquo_reg[c][QB-2:0], 1'b0};
                end
            end
        end
    end

    // Saturate and apply default fill for missing channels
    logic [PIXW-1:0] chan [CHN];

    always_comb
    begin
        for (int c = 0; c < CHN; c++)
        begin
            if (CCW'(c) < common)
            begin
                if (qneg_reg[c])
                begin
                    chan[c] = '0;
                end
                else if (qquo_reg[c] > QB'(FULL))
                begin
                    chan[c] = FULL;
                end
                else
                begin
                    chan[c] = qquo_reg[c][PIXW-1:0];
                end
            end
            else if (CCW'(c) < tc)
            begin
                chan[c] = (tc == CCW'(CHN) && c == CHN - 1) ? FULL : '0;
            end
            else
            begin
                chan[c] = '0;
            end
        end
    end

    // Output register: hold the result until the receiver takes it
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x      <= px_reg;
            out_y      <= py_reg;
            out_chan_0 <= chan[0];
            out_chan_1 <= chan[1];
            out_chan_2 <= chan[2];
            out_chan_3 <= chan[3];
        end
    end

    assign out_valid = out_valid_reg;

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten");

    // A loaded result is presented next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

    // The single memory port never sees a write and a read together
    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("frame port conflict");

endmodule
`default_nettype wire

[rtl/bilinear_image_scaler.sv]
// Bilinear image scaler with half-pixel centers over an on-chip frame store.
// Input channel (in_valid/in_ready): operation 0 loads a source pixel at
// (pos_x, pos_y), operation 1 samples destination pixel (pos_x, pos_y).
// Output channel (out_valid/out_ready): one result per valid sample, none
// for loads or for items outside the configured sizes.
// Configuration: APB-style port, registers at 4*index: source width/height,
// target width/height, source/target channel counts. Write only when idle.
// Flow: a load is written to the frame store when it is accepted. A sample
// runs per-axis coordinate division in two bit-serial dividers, then neighbor
// reads through the single frame-memory port, then bit-serial rounded
// division of the four channel sums. One item is in work at a time.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and waits before loading the next one.
// Reset clears control state and sets sizes to 1 and channel counts to 4;
// frame contents are undefined until written.
`default_nettype none
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [4:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            operation,
    input  wire logic [PW-1:0]   pos_x,
    input  wire logic [PW-1:0]   pos_y,
    input  wire logic [PIXW-1:0] in_chan_0,
    input  wire logic [PIXW-1:0] in_chan_1,
    input  wire logic [PIXW-1:0] in_chan_2,
    input  wire logic [PIXW-1:0] in_chan_3,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [PW-1:0]        out_x,
    output logic [PW-1:0]        out_y,
    output logic [PIXW-1:0]      out_chan_0,
    output logic [PIXW-1:0]      out_chan_1,
    output logic [PIXW-1:0]      out_chan_2,
    output logic [PIXW-1:0]      out_chan_3
);

    logic [CW-1:0]  src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [CCW-1:0] src_ch_reg, dst_ch_reg;
    reg_idx_t       idx;
    logic           wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= CW'(1);
            src_h_reg  <= CW'(1);
            dst_w_reg  <= CW'(1);
            dst_h_reg  <= CW'(1);
            src_ch_reg <= CCW'(CHN);
            dst_ch_reg <= CCW'(CHN);
        end
        else if (wr)
        begin
            unique case (idx)
                REG_SRC_W:  src_w_reg  <= pwdata[CW-1:0];
                REG_SRC_H:  src_h_reg  <= pwdata[CW-1:0];
                REG_DST_W:  dst_w_reg  <= pwdata[CW-1:0];
                REG_DST_H:  dst_h_reg  <= pwdata[CW-1:0];
                REG_SRC_CH: src_ch_reg <= pwdata[CCW-1:0];
                REG_DST_CH: dst_ch_reg <= pwdata[CCW-1:0];
                default:    ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (idx)
            REG_SRC_W:  prdata = 32'(src_w_reg);
            REG_SRC_H:  prdata = 32'(src_h_reg);
            REG_DST_W:  prdata = 32'(dst_w_reg);
            REG_DST_H:  prdata = 32'(dst_h_reg);
            REG_SRC_CH: prdata = 32'(src_ch_reg);
            REG_DST_CH: prdata = 32'(dst_ch_reg);
            default:    prdata = '0;
        endcase
    end

    cmd_t  cmd;
    stat_t stat;

    bis_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bis_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .source_width         (src_w_reg),
        .source_height        (src_h_reg),
        .target_width         (dst_w_reg),
        .target_height        (dst_h_reg),
        .source_channel_count (src_ch_reg),
        .target_channel_count (dst_ch_reg),
        .pos_x                (pos_x),
        .pos_y                (pos_y),
        .in_chan_0            (in_chan_0),
        .in_chan_1            (in_chan_1),
        .in_chan_2            (in_chan_2),
        .in_chan_3            (in_chan_3),
        .cmd                  (cmd),
        .stat                 (stat),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .out_x                (out_x),
        .out_y                (out_y),
        .out_chan_0           (out_chan_0),
        .out_chan_1           (out_chan_1),
        .out_chan_2           (out_chan_2),
        .out_chan_3           (out_chan_3)
    );

endmodule
`default_nettype wire
